/* rtl/core/mts_pkg.sv */
`timescale 1ns / 1ps
// Package for the minimum tracking stack: data types, request and status codes,
// the empty-stack constants and the shift control struct shared by the cell chain.
// No dependencies.
package mts_pkg;

    localparam int DATA_W = 32;
    localparam int DEPTH_OUT_W = 8;
    localparam int STACK_DEPTH_DEF = 128;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t EMPTY_TOP = -32'sd1;
    localparam word_t EMPTY_MIN = 32'sd100000;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

/* rtl/core/mts_cell.sv */
`timescale 1ns / 1ps
// One stack cell: holds a single entry and takes the entry of a neighbor on a shift.
// Depends on mts_pkg.
module mts_cell (
    input  logic                clk,
    input  mts_pkg::shift_ctrl_t ctrl,
    input  mts_pkg::word_t      from_above,
    input  mts_pkg::word_t      from_below,
    output mts_pkg::word_t      q
);
    import mts_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        if (ctrl.push)
        begin
            data_next = from_above;
        end
        else if (ctrl.pop)
        begin
            data_next = from_below;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* rtl/core/mts_chain.sv */
`timescale 1ns / 1ps
// A row of stack cells with the top entry in cell zero; a push shifts every entry one
// cell down and a pop one cell up. Depends on mts_pkg and mts_cell.
module mts_chain #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  mts_pkg::shift_ctrl_t ctrl,
    input  mts_pkg::word_t       push_data,
    output mts_pkg::word_t       top_q,
    output mts_pkg::word_t       second_q
);
    import mts_pkg::*;

    word_t cell_q [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            word_t above;
            word_t below;
            if (i == 0)
            begin : g_first
                assign above = push_data;
            end
            else
            begin : g_inner_above
                assign above = cell_q[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign below = '0;
            end
            else
            begin : g_inner_below
                assign below = cell_q[i+1];
            end
            mts_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .from_above (above),
                .from_below (below),
                .q          (cell_q[i])
            );
        end
    endgenerate

    assign top_q    = cell_q[0];
    assign second_q = cell_q[1];

endmodule

/* rtl/core/min_tracking_stack.sv */
`timescale 1ns / 1ps
// Top level of the minimum tracking stack: request decode, counters, output register.
// Depends on mts_pkg and mts_chain.
//
// A bounded stack of signed 32-bit values that also reports the minimum of the values
// it holds. Each request transaction on the slave side (tuser selects push, pop or read)
// gives exactly one result transaction that describes the state after the request.
// The values and the running minima live in two rows of STACK_DEPTH cells, and every
// request moves each cell by at most one place, so one transaction is accepted per cycle
// while the result register is free or being taken. The result is registered and
// appears in the cycle after acceptance. A push to a full stack is dropped with
// status 1; a pop of an empty stack is ignored with status 2. An empty stack reads top
// -1 and minimum 100000. Request code 3 acts as a read.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // Fields from bit 0: value[31:0].
    input  logic [1:0]  s_tuser,   // Fields from bit 0: req_type[1:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // Fields from bit 0: top_value[31:0], min_value[31:0],
                                   // is_empty[0], depth_used[7:0], zero fill[6:0].
    output logic [1:0]  m_tuser    // Fields from bit 0: status[1:0].
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] value_count_reg, value_count_next;
    logic [CNT_W-1:0] min_count_reg, min_count_next;
    logic             m_tvalid_reg;

    word_t            top_reg, top_next;
    word_t            min_reg, min_next;
    logic             empty_reg, empty_next;
    logic [DEPTH_OUT_W-1:0] depth_reg, depth_next;
    status_t          status_reg, status_next;

    shift_ctrl_t      value_ctrl, min_ctrl;
    word_t            value_top, value_second, min_top, min_second;
    word_t            in_value;
    logic             accept;
    logic             do_value_push, do_value_pop, do_min_push, do_min_pop;
    word_t            new_top, new_min;

    assign in_value = word_t'(s_tdata);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        do_value_push    = 1'b0;
        do_value_pop     = 1'b0;
        do_min_push      = 1'b0;
        do_min_pop       = 1'b0;
        value_count_next = value_count_reg;
        min_count_next   = min_count_reg;
        status_next      = ST_DONE;
        case (s_tuser)
            REQ_PUSH:
            begin
                if (value_count_reg >= CNT_FULL)
                begin
                    status_next = ST_FULL;
                end
                else if (value_count_reg == '0 || min_count_reg == '0)
                begin
                    do_value_push    = 1'b1;
                    do_min_push      = 1'b1;
                    value_count_next = CNT_ONE;
                    min_count_next   = CNT_ONE;
                end
                else
                begin
                    do_value_push    = 1'b1;
                    value_count_next = value_count_reg + CNT_ONE;
                    if (in_value <= min_top && min_count_reg < CNT_FULL)
                    begin
                        do_min_push    = 1'b1;
                        min_count_next = min_count_reg + CNT_ONE;
                    end
                end
            end
            REQ_POP:
            begin
                if (value_count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_value_pop     = 1'b1;
                    value_count_next = value_count_reg - CNT_ONE;
                    if (min_count_reg != '0 && value_top == min_top)
                    begin
                        do_min_pop     = 1'b1;
                        min_count_next = min_count_reg - CNT_ONE;
                    end
                    if (value_count_reg == CNT_ONE)
                    begin
                        min_count_next = '0;
                    end
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    assign value_ctrl.push = accept && do_value_push;
    assign value_ctrl.pop  = accept && do_value_pop;
    assign min_ctrl.push   = accept && do_min_push;
    assign min_ctrl.pop    = accept && do_min_pop;

    always_comb
    begin
        if (do_value_push)
        begin
            new_top = in_value;
        end
        else if (do_value_pop)
        begin
            new_top = value_second;
        end
        else
        begin
            new_top = value_top;
        end
        if (do_min_push)
        begin
            new_min = in_value;
        end
        else if (do_min_pop)
        begin
            new_min = min_second;
        end
        else
        begin
            new_min = min_top;
        end
        depth_next = DEPTH_OUT_W'(value_count_next);
        if (value_count_next == '0)
        begin
            top_next   = EMPTY_TOP;
            min_next   = EMPTY_MIN;
            empty_next = 1'b1;
        end
        else
        begin
            top_next   = new_top;
            min_next   = (min_count_next != '0) ? new_min : EMPTY_MIN;
            empty_next = 1'b0;
        end
    end

    mts_chain #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_value_chain (
        .clk       (clk),
        .ctrl      (value_ctrl),
        .push_data (in_value),
        .top_q     (value_top),
        .second_q  (value_second)
    );

    mts_chain #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_min_chain (
        .clk       (clk),
        .ctrl      (min_ctrl),
        .push_data (in_value),
        .top_q     (min_top),
        .second_q  (min_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= '0;
            min_count_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                value_count_reg <= value_count_next;
                min_count_reg   <= min_count_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg    <= top_next;
            min_reg    <= min_next;
            empty_reg  <= empty_next;
            depth_reg  <= depth_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, depth_reg, empty_reg, min_reg, top_reg};
    assign m_tuser  = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        value_count_reg <= CNT_FULL)
        else $error("Stack count exceeds the stack depth.");

    a_min_le_value: assert property (@(posedge clk) disable iff (!rst_n)
        min_count_reg <= value_count_reg)
        else $error("Minima stack is deeper than the value stack.");

    a_min_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (min_count_reg == '0) == (value_count_reg == '0))
        else $error("Minima stack emptiness disagrees with the value stack.");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == REQ_PUSH && value_count_reg != '0 &&
         value_count_reg < CNT_FULL)
        |=> value_count_reg == $past(value_count_reg) + CNT_ONE)
        else $error("Accepted push did not grow the stack by one.");

endmodule
